/* rtl/ddsp_pkg.sv */
// Shared types, register indexes and saturation helpers for the
// differential drive speed PID block. No dependencies.
package ddsp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOW_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH_LIMIT = 3'd7;

    localparam logic [15:0] RST_SPEED_SCALE      = 16'd29537;
    localparam logic [23:0] RST_LINEAR_GAIN      = 24'd174467;
    localparam logic [23:0] RST_TURN_GAIN        = 24'd12562;
    localparam logic [23:0] RST_PROP_GAIN        = 24'd3932;
    localparam logic [23:0] RST_INTEG_GAIN       = 24'd0;
    localparam logic [23:0] RST_DERIV_GAIN       = 24'd32768;
    localparam logic [15:0] RST_DRIVE_LOW_LIMIT  = 16'd2000;
    localparam logic [15:0] RST_DRIVE_HIGH_LIMIT = 16'd10000;

    typedef struct packed {
        logic [15:0] speed_scale;
        logic [23:0] linear_gain;
        logic [23:0] turn_gain;
        logic [23:0] prop_gain;
        logic [23:0] integ_gain;
        logic [23:0] deriv_gain;
        logic [15:0] drive_low_limit;
        logic [15:0] drive_high_limit;
    } ddsp_cfg_t;

    // one enable per datapath step, driven by the top-level sequencer
    typedef struct packed {
        logic mul_en;
        logic sat_en;
        logic err_en;
        logic delta_en;
        logic prod_en;
        logic add_en;
        logic drive_en;
        logic mag_en;
    } ddsp_ctl_t;

    typedef struct packed {
        logic        [15:0] fwd;
        logic        [15:0] rev;
        logic signed [31:0] rpm;
    } ddsp_lane_out_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sh0000_7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < -64'sh0000_8000_0000_0000)
            r = -48'sh8000_0000_0000;
        else
            r = v[47:0];
        return r;
    endfunction

endpackage

/* rtl/ddsp_if.sv */
// Valid/ready channel interfaces for the tick input and the result output.
// No dependencies.
interface ddsp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic signed [31:0] target_linear;
    logic signed [31:0] target_angular;

    modport source (output valid, right_count, left_count, target_linear, target_angular,
                    input ready);
    modport sink   (input valid, right_count, left_count, target_linear, target_angular,
                    output ready);
endinterface

interface ddsp_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] right_fwd_pwm;
    logic        [15:0] right_rev_pwm;
    logic        [15:0] left_fwd_pwm;
    logic        [15:0] left_rev_pwm;
    logic signed [31:0] right_rpm;
    logic signed [31:0] left_rpm;

    modport source (output valid, right_fwd_pwm, right_rev_pwm, left_fwd_pwm, left_rev_pwm,
                    right_rpm, left_rpm, input ready);
    modport sink   (input valid, right_fwd_pwm, right_rev_pwm, left_fwd_pwm, left_rev_pwm,
                    right_rpm, left_rpm, output ready);
endinterface

/* rtl/ddsp_kin.sv */
// Differential kinematics: wheel RPM targets from linear and angular speed.
// Depends on ddsp_pkg.
module ddsp_kin (
    input  logic                clk,
    input  ddsp_pkg::ddsp_ctl_t ctl,
    input  ddsp_pkg::ddsp_cfg_t cfg,
    input  logic signed [31:0]  target_linear,
    input  logic signed [31:0]  target_angular,
    output logic signed [31:0]  right_target,
    output logic signed [31:0]  left_target
);
    import ddsp_pkg::*;

    logic signed [56:0] lin_x, lin_gain_x, ang_x, ang_gain_x;
    logic signed [56:0] lin_term_reg, ang_term_reg;
    logic signed [63:0] lin_w, ang_w;
    logic signed [31:0] right_target_reg, left_target_reg;

    always_comb
    begin
        lin_x      = {{25{target_linear[31]}}, target_linear};
        ang_x      = {{25{target_angular[31]}}, target_angular};
        lin_gain_x = {33'b0, cfg.linear_gain};
        ang_gain_x = {33'b0, cfg.turn_gain};
        lin_w      = {{7{lin_term_reg[56]}}, lin_term_reg};
        ang_w      = {{7{ang_term_reg[56]}}, ang_term_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            lin_term_reg <= lin_x * lin_gain_x;
            ang_term_reg <= ang_x * ang_gain_x;
        end
        if (ctl.sat_en)
        begin
            right_target_reg <= sat32(lin_w + ang_w);
            left_target_reg  <= sat32(lin_w - ang_w);
        end
    end

    assign right_target = right_target_reg;
    assign left_target  = left_target_reg;

endmodule

/* rtl/ddsp_wheel.sv */
// One wheel lane: speed estimate, error, incremental PID and drive clamp.
// Depends on ddsp_pkg.
module ddsp_wheel #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ddsp_pkg::ddsp_ctl_t      ctl,
    input  ddsp_pkg::ddsp_cfg_t      cfg,
    input  logic                     mirror,
    input  logic [COUNT_WIDTH-1:0]   count,
    input  logic signed [31:0]       target,
    output ddsp_pkg::ddsp_lane_out_t lane_out
);
    import ddsp_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + 17;

    // state kept between ticks
    logic        [COUNT_WIDTH-1:0] prev_count_reg;
    logic signed [31:0]            prev_err_reg, prev_err_next;
    logic signed [47:0]            sum_reg, sum_next;
    logic signed [16:0]            prev_drive_reg, prev_drive_next;

    // per-tick pipeline registers
    logic signed [PROD_W-1:0] prod_reg, prod_next, diff_x, scale_x;
    logic        [COUNT_WIDTH-1:0] diff;
    logic signed [63:0] rpm_shift;
    logic signed [31:0] rpm_reg, rpm_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [32:0] delta_reg, delta_next;
    logic signed [57:0] p_reg, err_x, kp_x;
    logic signed [58:0] d_reg, delta_x, kd_x;
    logic signed [56:0] ihi_reg, hi_x, ki_x;
    logic        [39:0] ilo_reg;
    logic signed [59:0] pd_reg, pd_next, i_reg, i_next, drive_reg;
    logic signed [59:0] p_w, d_w, prev_w;
    logic        [59:0] abs_drive;
    logic        [43:0] mag_full;
    logic        [15:0] mag;
    logic               pos;
    logic        [15:0] fwd_reg, rev_reg;

    always_comb
    begin
        diff      = count - prev_count_reg;
        diff_x    = {{17{diff[COUNT_WIDTH-1]}}, diff};
        scale_x   = {{(PROD_W-16){1'b0}}, cfg.speed_scale};
        prod_next = diff_x * scale_x;

        rpm_shift = {{(64-PROD_W){prod_reg[PROD_W-1]}}, prod_reg} <<< 8;
        rpm_next  = sat32(mirror ? -rpm_shift : rpm_shift);

        err_next   = sat32({{32{target[31]}}, target} - {{32{rpm_reg[31]}}, rpm_reg});
        delta_next = {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
        sum_next   = sat48({{16{sum_reg[47]}}, sum_reg} + {{32{err_reg[31]}}, err_reg});
        prev_err_next = err_reg;

        err_x   = {{26{err_reg[31]}}, err_reg};
        kp_x    = {34'b0, cfg.prop_gain};
        delta_x = {{26{delta_reg[32]}}, delta_reg};
        kd_x    = {35'b0, cfg.deriv_gain};
        hi_x    = {{25{sum_reg[47]}}, sum_reg[47:16]};
        ki_x    = {33'b0, cfg.integ_gain};

        // floor(x / 2^16) is an arithmetic shift
        p_w     = $signed({{2{p_reg[57]}}, p_reg}) >>> 16;
        d_w     = $signed({d_reg[58], d_reg}) >>> 16;
        prev_w  = {{43{prev_drive_reg[16]}}, prev_drive_reg} <<< 16;
        pd_next = prev_w + p_w + d_w;
        i_next  = {{3{ihi_reg[56]}}, ihi_reg} + {36'b0, ilo_reg[39:16]};

        abs_drive = drive_reg[59] ? -drive_reg : drive_reg;
        mag_full  = abs_drive[59:16];
        if (mag_full > {28'b0, cfg.drive_high_limit})
            mag = cfg.drive_high_limit;
        else if (mag_full < {28'b0, cfg.drive_low_limit})
            mag = cfg.drive_low_limit;
        else
            mag = mag_full[15:0];

        // zero target counts as reverse
        pos             = target > 32'sd0;
        prev_drive_next = pos ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
            prev_err_reg   <= '0;
            sum_reg        <= '0;
            prev_drive_reg <= '0;
        end
        else
        begin
            if (ctl.mul_en)
                prev_count_reg <= count;
            if (ctl.delta_en)
            begin
                sum_reg      <= sum_next;
                prev_err_reg <= prev_err_next;
            end
            if (ctl.mag_en)
                prev_drive_reg <= prev_drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
            prod_reg <= prod_next;
        if (ctl.sat_en)
            rpm_reg <= rpm_next;
        if (ctl.err_en)
            err_reg <= err_next;
        if (ctl.delta_en)
            delta_reg <= delta_next;
        if (ctl.prod_en)
        begin
            p_reg   <= err_x * kp_x;
            d_reg   <= delta_x * kd_x;
            ihi_reg <= hi_x * ki_x;
            ilo_reg <= {16'b0, cfg.integ_gain} * {24'b0, sum_reg[15:0]};
        end
        if (ctl.add_en)
        begin
            pd_reg <= pd_next;
            i_reg  <= i_next;
        end
        if (ctl.drive_en)
            drive_reg <= pd_reg + i_reg;
        if (ctl.mag_en)
        begin
            fwd_reg <= pos ? mag : 16'd0;
            rev_reg <= pos ? 16'd0 : mag;
        end
    end

    assign lane_out.fwd = fwd_reg;
    assign lane_out.rev = rev_reg;
    assign lane_out.rpm = rpm_reg;

endmodule

/* rtl/differential_drive_speed_pid.sv */
// Two-wheel speed controller: one tick in, PWM compare values and speed
// estimates out. A tick is accepted only while the sequencer is idle; its result
// word is loaded after one multiply, saturate, error, delta/accumulate, four gain
// multiplies, two add steps and the clamp, then the load, and the next tick can be
// taken in the cycle after the load, so a tick is never taken before the last one
// is through; a result word that is not yet taken can stall the last step. Both
// wheels run in parallel lanes.
// Depends on ddsp_pkg, ddsp_if, ddsp_kin and ddsp_wheel.
module differential_drive_speed_pid #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ddsp_in_if.sink                          tick,
    ddsp_out_if.source                       result,
    input  logic                             cfg_wr_en,
    input  logic [ddsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ddsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ddsp_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SAT   = 4'd1;
    localparam logic [3:0] ST_ERR   = 4'd2;
    localparam logic [3:0] ST_DELTA = 4'd3;
    localparam logic [3:0] ST_PROD  = 4'd4;
    localparam logic [3:0] ST_ADD   = 4'd5;
    localparam logic [3:0] ST_DRIVE = 4'd6;
    localparam logic [3:0] ST_MAG   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]     state_reg, state_next;
    ddsp_cfg_t      cfg_reg;
    ddsp_ctl_t      ctl;
    logic           accept, load_out;
    logic signed [31:0] right_target, left_target;
    ddsp_lane_out_t right_out, left_out;

    logic           res_valid_reg;
    ddsp_lane_out_t res_right_reg, res_left_reg;

    assign accept   = tick.valid && tick.ready;
    assign load_out = (state_reg == ST_OUT) && (!res_valid_reg || result.ready);

    always_comb
    begin
        tick.ready   = (state_reg == ST_IDLE);
        ctl.mul_en   = accept;
        ctl.sat_en   = (state_reg == ST_SAT);
        ctl.err_en   = (state_reg == ST_ERR);
        ctl.delta_en = (state_reg == ST_DELTA);
        ctl.prod_en  = (state_reg == ST_PROD);
        ctl.add_en   = (state_reg == ST_ADD);
        ctl.drive_en = (state_reg == ST_DRIVE);
        ctl.mag_en   = (state_reg == ST_MAG);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SAT;
            ST_SAT:   state_next = ST_ERR;
            ST_ERR:   state_next = ST_DELTA;
            ST_DELTA: state_next = ST_PROD;
            ST_PROD:  state_next = ST_ADD;
            ST_ADD:   state_next = ST_DRIVE;
            ST_DRIVE: state_next = ST_MAG;
            ST_MAG:   state_next = ST_OUT;
            ST_OUT:   if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            cfg_reg.speed_scale      <= RST_SPEED_SCALE;
            cfg_reg.linear_gain      <= RST_LINEAR_GAIN;
            cfg_reg.turn_gain        <= RST_TURN_GAIN;
            cfg_reg.prop_gain        <= RST_PROP_GAIN;
            cfg_reg.integ_gain       <= RST_INTEG_GAIN;
            cfg_reg.deriv_gain       <= RST_DERIV_GAIN;
            cfg_reg.drive_low_limit  <= RST_DRIVE_LOW_LIMIT;
            cfg_reg.drive_high_limit <= RST_DRIVE_HIGH_LIMIT;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SPEED_SCALE:      cfg_reg.speed_scale      <= cfg_data[15:0];
                    REG_LINEAR_GAIN:      cfg_reg.linear_gain      <= cfg_data;
                    REG_TURN_GAIN:        cfg_reg.turn_gain        <= cfg_data;
                    REG_PROP_GAIN:        cfg_reg.prop_gain        <= cfg_data;
                    REG_INTEG_GAIN:       cfg_reg.integ_gain       <= cfg_data;
                    REG_DERIV_GAIN:       cfg_reg.deriv_gain       <= cfg_data;
                    REG_DRIVE_LOW_LIMIT:  cfg_reg.drive_low_limit  <= cfg_data[15:0];
                    REG_DRIVE_HIGH_LIMIT: cfg_reg.drive_high_limit <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_right_reg <= right_out;
            res_left_reg  <= left_out;
        end
    end

    ddsp_kin u_kin (
        .clk            (clk),
        .ctl            (ctl),
        .cfg            (cfg_reg),
        .target_linear  (tick.target_linear),
        .target_angular (tick.target_angular),
        .right_target   (right_target),
        .left_target    (left_target)
    );

    ddsp_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .cfg      (cfg_reg),
        .mirror   (1'b0),
        .count    (tick.right_count[COUNT_WIDTH-1:0]),
        .target   (right_target),
        .lane_out (right_out)
    );

    // left wheel is mounted mirrored, so its speed estimate is negated
    ddsp_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .cfg      (cfg_reg),
        .mirror   (1'b1),
        .count    (tick.left_count[COUNT_WIDTH-1:0]),
        .target   (left_target),
        .lane_out (left_out)
    );

    assign result.valid         = res_valid_reg;
    assign result.right_fwd_pwm = res_right_reg.fwd;
    assign result.right_rev_pwm = res_right_reg.rev;
    assign result.left_fwd_pwm  = res_left_reg.fwd;
    assign result.left_rev_pwm  = res_left_reg.rev;
    assign result.right_rpm     = res_right_reg.rpm;
    assign result.left_rpm      = res_left_reg.rpm;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> (state_reg == ST_SAT))
        else $error("accepted word did not start the datapath");

    a_mag_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAG) |=> (state_reg == ST_OUT))
        else $error("clamp step not followed by output step");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result word appeared outside the output step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result.ready && (state_reg == ST_OUT)) |=> (state_reg == ST_OUT))
        else $error("pending result word was overwritten");

endmodule

/* dv/differential_drive_speed_pid_test.sv */
// Self-checking testbench for differential_drive_speed_pid: drives control ticks,
// predicts each result word with its own two-wheel PID model and compares them.
// Depends on ddsp_pkg, ddsp_if and the block RTL.
module differential_drive_speed_pid_test;
    import ddsp_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 238;
    localparam int IDLE_PCT     = 31;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam longint S_MAX = 64'sd140737488355327;
    localparam longint S_MIN = -64'sd140737488355328;

    typedef struct packed {
        logic signed [31:0] right_count;
        logic signed [31:0] left_count;
        logic signed [31:0] target_linear;
        logic signed [31:0] target_angular;
    } tick_word_t;

    typedef struct packed {
        logic        [15:0] right_fwd_pwm;
        logic        [15:0] right_rev_pwm;
        logic        [15:0] left_fwd_pwm;
        logic        [15:0] left_rev_pwm;
        logic signed [31:0] right_rpm;
        logic signed [31:0] left_rpm;
    } drive_word_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ddsp_in_if  tick_ch ();
    ddsp_out_if result_ch ();

    differential_drive_speed_pid dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller copy: registers and per-wheel state, index 0 right, 1 left
    ddsp_cfg_t          gains;
    logic        [31:0] last_count [2];
    logic signed [31:0] last_error [2];
    logic signed [16:0] last_drive [2];
    logic signed [47:0] error_sum  [2];

    tick_word_t  queued_ticks [$];
    drive_word_t expected_drives [$];

    int unsigned ticks_sent     = 0;
    int unsigned ticks_taken    = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;
    int          tick_gap_pct   = IDLE_PCT;
    int          result_gap_pct = IDLE_PCT;
    logic [31:0] right_pos      = '0;
    logic [31:0] left_pos       = '0;
    tick_word_t  offer_word;
    drive_word_t want_word;
    drive_word_t got_word;

    always #HALF_PERIOD clk = ~clk;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // one wheel of the incremental PID; updates that wheel's state
    function automatic void wheel_step(input int side, input longint target, input longint rpm,
                                       output logic [15:0] fwd, output logic [15:0] rev);
        longint err, sum, sum_hi, sum_lo, kp, ki, kd, prev_drv, prev_err, drv, mag, neg;
        longint lo_lim, hi_lim;
        kp       = gains.prop_gain;
        ki       = gains.integ_gain;
        kd       = gains.deriv_gain;
        lo_lim   = gains.drive_low_limit;
        hi_lim   = gains.drive_high_limit;
        prev_drv = last_drive[side];
        prev_err = last_error[side];
        err      = clip(target - rpm, Q_MIN, Q_MAX);
        sum      = clip(longint'(error_sum[side]) + err, S_MIN, S_MAX);
        // split the sum so ki*sum cannot overflow 64 bits
        sum_hi   = sum >>> 16;
        sum_lo   = sum & 64'hFFFF;
        drv = prev_drv * 65536 + ((kp * err) >>> 16) + ki * sum_hi + ((ki * sum_lo) >>> 16)
            + ((kd * (err - prev_err)) >>> 16);
        mag = (drv < 0 ? -drv : drv) >>> 16;
        if (mag > hi_lim)
            mag = hi_lim;
        else if (mag < lo_lim)
            mag = lo_lim;
        error_sum[side]  = sum[47:0];
        last_error[side] = err[31:0];
        neg = -mag;
        if (target > 0)
        begin
            last_drive[side] = mag[16:0];
            fwd = mag[15:0];
            rev = '0;
        end
        else
        begin
            // zero target counts as reverse
            last_drive[side] = neg[16:0];
            fwd = '0;
            rev = mag[15:0];
        end
    endfunction

    function automatic drive_word_t predict_drive(input tick_word_t w);
        drive_word_t r;
        logic [31:0] raw_r, raw_l;
        logic [15:0] rf, rr, lf, lr;
        longint dr, dl, sc, rpm_r, rpm_l, lin, ang, lterm, aterm;
        raw_r = w.right_count - last_count[0];
        raw_l = w.left_count - last_count[1];
        last_count[0] = w.right_count;
        last_count[1] = w.left_count;
        dr    = $signed(raw_r);
        dl    = $signed(raw_l);
        sc    = gains.speed_scale;
        sc    = sc * 256;
        rpm_r = clip(dr * sc, Q_MIN, Q_MAX);
        rpm_l = clip(-(dl * sc), Q_MIN, Q_MAX);    // left wheel is mirrored
        lin   = w.target_linear;
        ang   = w.target_angular;
        lterm = gains.linear_gain;
        aterm = gains.turn_gain;
        lterm = lin * lterm;
        aterm = ang * aterm;
        wheel_step(0, clip(lterm + aterm, Q_MIN, Q_MAX), rpm_r, rf, rr);
        wheel_step(1, clip(lterm - aterm, Q_MIN, Q_MAX), rpm_l, lf, lr);
        r.right_fwd_pwm = rf;
        r.right_rev_pwm = rr;
        r.left_fwd_pwm  = lf;
        r.left_rev_pwm  = lr;
        r.right_rpm     = rpm_r[31:0];
        r.left_rpm      = rpm_l[31:0];
        return r;
    endfunction

    function automatic longint spread(input longint span);
        longint r;
        r = $urandom_range(32'(2 * span));
        return r - span;
    endfunction

    // Mostly plausible motion scaled so speeds and targets stay unsaturated,
    // with some large jumps and some fully random words.
    function automatic tick_word_t next_tick();
        tick_word_t w;
        longint sc, cnt_span, lin_span, ang_span, lin, ang;
        int pick;
        pick     = $urandom_range(99);
        sc       = gains.speed_scale;
        cnt_span = 1073741824 / (sc * 256 + 1) + 1;
        lin_span = gains.linear_gain;
        lin_span = 1073741824 / (lin_span + 1) + 1;
        ang_span = gains.turn_gain;
        ang_span = 1073741824 / (ang_span + 1) + 1;
        if (pick < 75)
        begin
            right_pos = right_pos + 32'(spread(cnt_span));
            left_pos  = left_pos + 32'(spread(cnt_span));
            lin = spread(lin_span);
            ang = spread(ang_span);
            if ($urandom_range(9) == 0)
            begin
                lin = 0;
                ang = 0;
            end
        end
        else if (pick < 90)
        begin
            right_pos = right_pos + $urandom();
            left_pos  = left_pos + 32'(spread(cnt_span * 64));
            lin = int'($urandom());
            ang = spread(ang_span * 16);
        end
        else
        begin
            right_pos = $urandom();
            left_pos  = $urandom();
            lin = int'($urandom());
            ang = int'($urandom());
        end
        w.right_count    = right_pos;
        w.left_count     = left_pos;
        w.target_linear  = lin[31:0];
        w.target_angular = ang[31:0];
        return w;
    endfunction

    task automatic add_tick(input logic [31:0] rc, input logic [31:0] lc,
                            input logic [31:0] lin, input logic [31:0] ang);
        tick_word_t w;
        w.right_count    = rc;
        w.left_count     = lc;
        w.target_linear  = lin;
        w.target_angular = ang;
        queued_ticks.push_back(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_SPEED_SCALE:      gains.speed_scale      = value[15:0];
            REG_LINEAR_GAIN:      gains.linear_gain      = value;
            REG_TURN_GAIN:        gains.turn_gain        = value;
            REG_PROP_GAIN:        gains.prop_gain        = value;
            REG_INTEG_GAIN:       gains.integ_gain       = value;
            REG_DERIV_GAIN:       gains.deriv_gain       = value;
            REG_DRIVE_LOW_LIMIT:  gains.drive_low_limit  = value[15:0];
            REG_DRIVE_HIGH_LIMIT: gains.drive_high_limit = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_gains(input logic [15:0] scale, input logic [23:0] lin_g,
                               input logic [23:0] turn_g, input logic [23:0] kp,
                               input logic [23:0] ki, input logic [23:0] kd,
                               input logic [15:0] lo_lim, input logic [15:0] hi_lim);
        write_reg(REG_SPEED_SCALE, {8'd0, scale});
        write_reg(REG_LINEAR_GAIN, lin_g);
        write_reg(REG_TURN_GAIN, turn_g);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_DRIVE_LOW_LIMIT, {8'd0, lo_lim});
        write_reg(REG_DRIVE_HIGH_LIMIT, {8'd0, hi_lim});
    endtask

    task automatic drain();
        while (queued_ticks.size() != 0 || ticks_sent != ticks_taken ||
               expected_drives.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // tick driver: a word stays offered until it is taken
    always @(negedge clk)
    begin
        if (rst_n && ticks_sent == ticks_taken)
        begin
            if (queued_ticks.size() != 0 && $urandom_range(99) >= tick_gap_pct)
            begin
                offer_word = queued_ticks.pop_front();
                tick_ch.valid          <= 1'b1;
                tick_ch.right_count    <= offer_word.right_count;
                tick_ch.left_count     <= offer_word.left_count;
                tick_ch.target_linear  <= offer_word.target_linear;
                tick_ch.target_angular <= offer_word.target_angular;
                ticks_sent++;
            end
            else
                tick_ch.valid <= 1'b0;
        end
    end

    // result receiver: random stalls plus requested long hold-offs
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_requests != holds_served)
        begin
            result_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= result_gap_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                expected_drives.push_back(predict_drive({tick_ch.right_count, tick_ch.left_count,
                                                         tick_ch.target_linear,
                                                         tick_ch.target_angular}));
                ticks_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got_word = {result_ch.right_fwd_pwm, result_ch.right_rev_pwm,
                            result_ch.left_fwd_pwm, result_ch.left_rev_pwm,
                            result_ch.right_rpm, result_ch.left_rpm};
                if (expected_drives.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected nothing, got %h",
                             $time, got_word);
                    mismatches++;
                end
                else
                begin
                    want_word = expected_drives.pop_front();
                    check_field("right_fwd_pwm", want_word.right_fwd_pwm, got_word.right_fwd_pwm);
                    check_field("right_rev_pwm", want_word.right_rev_pwm, got_word.right_rev_pwm);
                    check_field("left_fwd_pwm", want_word.left_fwd_pwm, got_word.left_fwd_pwm);
                    check_field("left_rev_pwm", want_word.left_rev_pwm, got_word.left_rev_pwm);
                    check_field("right_rpm", want_word.right_rpm, got_word.right_rpm);
                    check_field("left_rpm", want_word.left_rpm, got_word.left_rpm);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        tick_ch.valid          = 1'b0;
        tick_ch.right_count    = '0;
        tick_ch.left_count     = '0;
        tick_ch.target_linear  = '0;
        tick_ch.target_angular = '0;
        result_ch.ready        = 1'b0;
        gains = {RST_SPEED_SCALE, RST_LINEAR_GAIN, RST_TURN_GAIN, RST_PROP_GAIN,
                 RST_INTEG_GAIN, RST_DERIV_GAIN, RST_DRIVE_LOW_LIMIT, RST_DRIVE_HIGH_LIMIT};
        for (int s = 0; s < 2; s++)
        begin
            last_count[s] = '0;
            last_error[s] = '0;
            last_drive[s] = '0;
            error_sum[s]  = '0;
        end
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // reset gains: zero target, both signs, saturation, encoder wrap
        add_tick(32'd0, 32'd0, 32'd0, 32'd0);
        add_tick(32'd100, -32'sd100, 32'd10, 32'd0);
        add_tick(32'd90, -32'sd95, -32'sd10, 32'd5);
        add_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_tick(32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'd20, -32'sd3);
        add_tick(32'h8000_0010, 32'h8000_0010, 32'd20, -32'sd3);
        add_tick(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_tick(32'd5, -32'sd5, 32'd0, 32'd100);
        add_tick(32'd3, -32'sd2, 32'd0, -32'sd100);
        add_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // low limit above high limit
        write_gains(RST_SPEED_SCALE, RST_LINEAR_GAIN, RST_TURN_GAIN, RST_PROP_GAIN,
                    24'd300, RST_DERIV_GAIN, 16'd5000, 16'd3000);
        add_tick(32'd2, 32'd1, 32'd1, 32'd0);
        add_tick(32'd4, 32'd1, -32'sd40, 32'd7);
        add_tick(32'd4, 32'd9, 32'h7FFF_FFFF, 32'd0);
        add_tick(32'h1000_0000, 32'd9, 32'd0, 32'd0);
        drain();

        // zero limits force zero magnitude, then zero gains keep it at zero
        write_gains(RST_SPEED_SCALE, RST_LINEAR_GAIN, RST_TURN_GAIN, RST_PROP_GAIN,
                    RST_INTEG_GAIN, RST_DERIV_GAIN, 16'd0, 16'd0);
        add_tick(32'd50, 32'd50, 32'd30, 32'd10);
        add_tick(32'd60, 32'd40, -32'sd30, 32'd0);
        add_tick(32'd60, 32'd40, 32'd0, 32'd0);
        drain();
        write_gains(RST_SPEED_SCALE, RST_LINEAR_GAIN, RST_TURN_GAIN, 24'd0,
                    24'd0, 24'd0, 16'd0, 16'hFFFF);
        add_tick(32'd70, 32'd30, 32'd25, 32'd0);
        add_tick(32'd80, 32'd20, -32'sd25, 32'd4);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: write_gains(RST_SPEED_SCALE, RST_LINEAR_GAIN, RST_TURN_GAIN,
                               RST_PROP_GAIN, 24'd700, RST_DERIV_GAIN,
                               RST_DRIVE_LOW_LIMIT, RST_DRIVE_HIGH_LIMIT);
                1: write_gains(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                               24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF);
                2: write_gains(16'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 16'd0, 16'd0);
                3: write_gains(16'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 16'd0, 16'hFFFF);
                default: write_gains(16'($urandom_range(16'hFFFF)),
                                     24'($urandom_range(24'hFF_FFFF)),
                                     24'($urandom_range(24'hFF_FFFF)),
                                     24'($urandom_range(24'hFF_FFFF)),
                                     24'($urandom_range(24'hFF_FFFF)),
                                     24'($urandom_range(24'hFF_FFFF)),
                                     16'($urandom_range(16'hFFFF)),
                                     16'($urandom_range(16'hFFFF)));
            endcase
            // one phase runs flat out on both sides
            tick_gap_pct   = (phase == 1) ? 0 : IDLE_PCT;
            result_gap_pct = (phase == 1) ? 0 : IDLE_PCT;
            if (phase == 4)
                hold_requests++;
            for (int i = 0; i < PHASE_TICKS; i++)
                queued_ticks.push_back(next_tick());
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_drives.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
